>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define SKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define SKT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

  localparam int SKT_DEPTH = 16;
  localparam int SLOT_N    = 16;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_READ   = 2'd2
  } skt_kind_t;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_DUPLICATE = 3'd1;
  localparam logic [2:0] STAT_FOUND     = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_RANGE     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RES
  } skt_state_t;

  typedef struct packed {
    logic cmp;
    logic ins;
  } skt_ctrl_t;

  typedef struct packed {
    logic ge;
    logic match;
    logic sel;
    logic boundary;
  } skt_cell_stat_t;

endpackage

`default_nettype wire

>>> rtl/sorted_key_table_unit.sv
`default_nettype none

// Sorted key table. Each request is taken when start is high and busy is
// low, and exactly one result follows as a one-cycle out_valid strobe that
// the receiver cannot hold off. A request passes through these steps after
// acceptance: a compare state in which every cell of the chain compares its
// entry against the request key, a resolve state in which the flags are
// resolved and, for a new insert, the cells shift to open the sorted slot,
// and the strobe, during which busy is already low so the next request can
// be taken. A new request is refused while the compare and resolve states
// of the cell chain are still busy with the last one.

`include "assert_macros.svh"

module sorted_key_table_unit import skt_pkg::*; #(
  parameter int DEPTH = SKT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_part_key,
  input  wire logic        in_part_class,
  input  wire logic [15:0] in_detail_value,
  input  wire logic [3:0]  in_slot_index,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [4:0]       out_position,
  output logic [31:0]      out_key,
  output logic             out_class,
  output logic [15:0]      out_detail,
  output logic [4:0]       out_entry_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  skt_state_t       state_r, state_nxt;
  skt_ctrl_t        ctrl;
  skt_kind_t        req_kind_r;
  logic [31:0]      req_key_r;
  logic             req_cls_r;
  logic [15:0]      req_det_r;
  logic [3:0]       req_slot_r;
  logic [CNT_W-1:0] count_r;

  logic [31:0]      cell_key [DEPTH];
  logic             cell_cls [DEPTH];
  logic [15:0]      cell_det [DEPTH];
  skt_cell_stat_t   cell_stat [DEPTH];
  logic [DEPTH-1:0] match_v;
  logic [DEPTH-1:0] sel_v;

  logic             any_match;
  logic             any_sel;
  logic             full;
  logic [CNT_W-1:0] pos_match;
  logic [CNT_W-1:0] pos_ins;
  logic [31:0]      sel_key;
  logic             sel_cls;
  logic [15:0]      sel_det;

  logic             out_valid_r;
  logic [2:0]       out_status_r,  out_status_nxt;
  logic [4:0]       out_pos_r,     out_pos_nxt;
  logic [31:0]      out_key_r,     out_key_nxt;
  logic             out_cls_r,     out_cls_nxt;
  logic [15:0]      out_det_r,     out_det_nxt;
  logic [4:0]       out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = start ? ST_CMP : ST_IDLE;
      ST_CMP:  state_nxt = ST_RES;
      ST_RES:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = state_r != ST_IDLE;
    ctrl.cmp = state_r == ST_CMP;
    ctrl.ins = (state_r == ST_RES) && (req_kind_r == KIND_INSERT) && !any_match && !full;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_kind_r <= skt_kind_t'(in_kind);
      req_key_r  <= in_part_key;
      req_cls_r  <= in_part_class;
      req_det_r  <= in_detail_value;
      req_slot_r <= in_slot_index;
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic        prev_ge;
      logic [31:0] prev_key;
      logic        prev_cls;
      logic [15:0] prev_det;

      if (g == 0) begin : g_head
        assign prev_ge  = 1'b0;
        assign prev_key = req_key_r;
        assign prev_cls = req_cls_r;
        assign prev_det = req_det_r;
      end else begin : g_link
        assign prev_ge  = cell_stat[g-1].ge;
        assign prev_key = cell_key[g-1];
        assign prev_cls = cell_cls[g-1];
        assign prev_det = cell_det[g-1];
      end

      skt_cell #(
        .CNT_W   (CNT_W),
        .CELL_ID (g)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .req_key  (req_key_r),
        .req_cls  (req_cls_r),
        .req_det  (req_det_r),
        .req_find (req_kind_r == KIND_FIND),
        .req_slot (req_slot_r),
        .count    (count_r),
        .prev_ge  (prev_ge),
        .prev_key (prev_key),
        .prev_cls (prev_cls),
        .prev_det (prev_det),
        .key_o    (cell_key[g]),
        .cls_o    (cell_cls[g]),
        .det_o    (cell_det[g]),
        .stat_o   (cell_stat[g])
      );

      assign match_v[g] = cell_stat[g].match;
      assign sel_v[g]   = cell_stat[g].sel;
    end
  endgenerate

  // Keys are unique, so at most one cell matches and at most one cell sits
  // on the insert boundary; plain OR reductions pick out their data.
  always_comb begin
    pos_match = '0;
    pos_ins   = '0;
    sel_key   = '0;
    sel_cls   = 1'b0;
    sel_det   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_match = pos_match | (match_v[i] ? CNT_W'(i) : '0);
      pos_ins   = pos_ins | (cell_stat[i].boundary ? CNT_W'(i) : '0);
      sel_key   = sel_key | (sel_v[i] ? cell_key[i] : '0);
      sel_cls   = sel_cls | (sel_v[i] & cell_cls[i]);
      sel_det   = sel_det | (sel_v[i] ? cell_det[i] : '0);
    end
  end

  assign any_match = |match_v;
  assign any_sel   = |sel_v;
  assign full      = count_r == CNT_W'(DEPTH);

  always_comb begin
    out_status_nxt = STAT_RANGE;
    out_pos_nxt    = '0;
    out_key_nxt    = '0;
    out_cls_nxt    = 1'b0;
    out_det_nxt    = '0;
    unique case (req_kind_r)
      KIND_INSERT: begin
        if (any_match) begin
          out_status_nxt = STAT_DUPLICATE;
          out_pos_nxt    = 5'(pos_match);
        end else if (full) begin
          out_status_nxt = STAT_FULL;
          out_pos_nxt    = 5'(count_r);
        end else begin
          out_status_nxt = STAT_INSERTED;
          out_pos_nxt    = 5'(pos_ins);
        end
      end
      KIND_FIND: begin
        if (any_match) begin
          out_status_nxt = STAT_FOUND;
          out_pos_nxt    = 5'(pos_match);
          out_key_nxt    = sel_key;
          out_cls_nxt    = sel_cls;
          out_det_nxt    = sel_det;
        end else begin
          out_status_nxt = STAT_NOT_FOUND;
          out_pos_nxt    = 5'(count_r);
        end
      end
      KIND_READ: begin
        out_pos_nxt = 5'(req_slot_r);
        if (any_sel) begin
          out_status_nxt = STAT_FOUND;
          out_key_nxt    = sel_key;
          out_cls_nxt    = sel_cls;
          out_det_nxt    = sel_det;
        end
      end
      default: begin
        out_status_nxt = STAT_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= state_r == ST_RES;
      if (ctrl.ins) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RES) begin
      out_status_r <= out_status_nxt;
      out_pos_r    <= out_pos_nxt;
      out_key_r    <= out_key_nxt;
      out_cls_r    <= out_cls_nxt;
      out_det_r    <= out_det_nxt;
      out_cnt_r    <= 5'(count_r + CNT_W'(ctrl.ins));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_key         = out_key_r;
  assign out_class       = out_cls_r;
  assign out_detail      = out_det_r;
  assign out_entry_count = out_cnt_r;

  `SKT_NEVER(a_count_bound, count_r > CNT_W'(DEPTH), "Entry count exceeds table depth.")
  `SKT_ASSERT(a_strobe_src, out_valid |-> $past(state_r == ST_RES), "Result strobe without resolve.")
  `SKT_ASSERT(a_count_step, !$stable(count_r) |-> count_r == $past(count_r) + CNT_W'(1),
              "Entry count changed by other than one insert.")
  `SKT_ASSERT(a_one_match, state_r == ST_RES |-> $onehot0(match_v), "More than one key matched.")

endmodule

`default_nettype wire

>>> rtl/skt_cell.sv
`default_nettype none

module skt_cell import skt_pkg::*; #(
  parameter int CNT_W   = 5,
  parameter int CELL_ID = 0
) (
  input  wire logic             clk,
  input  wire skt_ctrl_t        ctrl,
  input  wire logic [31:0]      req_key,
  input  wire logic             req_cls,
  input  wire logic [15:0]      req_det,
  input  wire logic             req_find,
  input  wire logic [3:0]       req_slot,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             prev_ge,
  input  wire logic [31:0]      prev_key,
  input  wire logic             prev_cls,
  input  wire logic [15:0]      prev_det,
  output logic [31:0]           key_o,
  output logic                  cls_o,
  output logic [15:0]           det_o,
  output skt_cell_stat_t        stat_o
);

  logic [31:0] key_r;
  logic        cls_r;
  logic [15:0] det_r;
  logic        ge_r;
  logic        match_r;
  logic        sel_r;
  logic        valid;
  logic        slot_hit;

  assign valid    = count > CNT_W'(CELL_ID);
  assign slot_hit = (CELL_ID < SLOT_N) && (req_slot == 4'(CELL_ID));

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      ge_r    <= !(valid && (key_r < req_key));
      match_r <= valid && (key_r == req_key);
      sel_r   <= valid && (req_find ? (key_r == req_key) : slot_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (ge_r && !prev_ge) begin
        key_r <= req_key;
        cls_r <= req_cls;
        det_r <= req_det;
      end else if (prev_ge) begin
        key_r <= prev_key;
        cls_r <= prev_cls;
        det_r <= prev_det;
      end
    end
  end

  assign key_o           = key_r;
  assign cls_o           = cls_r;
  assign det_o           = det_r;
  assign stat_o.ge       = ge_r;
  assign stat_o.match    = match_r;
  assign stat_o.sel      = sel_r;
  assign stat_o.boundary = ge_r && !prev_ge;

endmodule

`default_nettype wire

>>> test/tb_sorted_key_table_unit.sv
`timescale 1ns / 100ps

module tb_sorted_key_table_unit;
  import skt_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1450;
  localparam int CALM_TAIL = 200;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic        cls;
    logic [15:0] detail;
    logic [3:0]  slot;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  position;
    logic [31:0] key;
    logic        cls;
    logic [15:0] detail;
    logic [4:0]  count;
  } reply_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    reply_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [31:0] in_part_key;
  logic        in_part_class;
  logic [15:0] in_detail_value;
  logic [3:0]  in_slot_index;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [4:0]  out_position;
  logic [31:0] out_key;
  logic        out_class;
  logic [15:0] out_detail;
  logic [4:0]  out_entry_count;

  logic [31:0] tbl_key [SKT_DEPTH];
  logic        tbl_class [SKT_DEPTH];
  logic [15:0] tbl_detail [SKT_DEPTH];
  int          tbl_fill;

  reply_t    pending_replies [$];
  stim_row_t directed_rows [$];
  reply_t    got_reply;
  int        n_errors;
  int        n_requests;
  int        n_replies;
  int        status_hits [8];

  sorted_key_table_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_part_key     (in_part_key),
    .in_part_class   (in_part_class),
    .in_detail_value (in_detail_value),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_key         (out_key),
    .out_class       (out_class),
    .out_detail      (out_detail),
    .out_entry_count (out_entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic request_t mk_req(logic [1:0] kind, logic [31:0] key, logic cls,
                                      logic [15:0] detail, logic [3:0] slot);
    request_t r;
    r = '{kind, key, cls, detail, slot};
    return r;
  endfunction

  function automatic reply_t mk_reply(logic [2:0] status, logic [4:0] position,
                                      logic [31:0] key, logic cls, logic [15:0] detail,
                                      logic [4:0] count);
    reply_t p;
    p = '{status, position, key, cls, detail, count};
    return p;
  endfunction

  function automatic reply_t apply_table_request(request_t r);
    reply_t rep;
    int hit;
    int slot;
    rep = '0;
    rep.status = STAT_RANGE;
    hit = tbl_fill;
    for (int i = tbl_fill - 1; i >= 0; i--) begin
      if (tbl_key[i] == r.key) hit = i;
    end
    case (r.kind)
      KIND_INSERT: begin
        if (hit < tbl_fill) begin
          rep.status = STAT_DUPLICATE;
          rep.position = 5'(hit);
        end else if (tbl_fill >= SKT_DEPTH) begin
          rep.status = STAT_FULL;
          rep.position = 5'(tbl_fill);
        end else begin
          slot = 0;
          while (slot < tbl_fill && tbl_key[slot] < r.key) slot++;
          for (int j = tbl_fill; j > slot; j--) begin
            tbl_key[j] = tbl_key[j - 1];
            tbl_class[j] = tbl_class[j - 1];
            tbl_detail[j] = tbl_detail[j - 1];
          end
          tbl_key[slot] = r.key;
          tbl_class[slot] = r.cls;
          tbl_detail[slot] = r.detail;
          tbl_fill++;
          rep.status = STAT_INSERTED;
          rep.position = 5'(slot);
        end
      end
      KIND_FIND: begin
        rep.position = 5'(hit);
        if (hit < tbl_fill) begin
          rep.status = STAT_FOUND;
          rep.key = tbl_key[hit];
          rep.cls = tbl_class[hit];
          rep.detail = tbl_detail[hit];
        end else begin
          rep.status = STAT_NOT_FOUND;
        end
      end
      KIND_READ: begin
        rep.position = 5'(r.slot);
        if (int'(r.slot) < tbl_fill) begin
          rep.status = STAT_FOUND;
          rep.key = tbl_key[r.slot];
          rep.cls = tbl_class[r.slot];
          rep.detail = tbl_detail[r.slot];
        end
      end
      default: begin
      end
    endcase
    rep.count = 5'(tbl_fill);
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  task automatic issue_request(input request_t r, input logic typed, input reply_t want,
                               input logic may_idle);
    reply_t predicted;
    int gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_kind <= r.kind;
    in_part_key <= r.key;
    in_part_class <= r.cls;
    in_detail_value <= r.detail;
    in_slot_index <= r.slot;
    do @(posedge clk); while (busy);
    predicted = apply_table_request(r);
    if (typed) predicted = want;
    pending_replies.push_back(predicted);
    status_hits[predicted.status]++;
    n_requests++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_replies++;
      if (pending_replies.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual status %0d",
                 $time, out_status);
        n_errors++;
      end else begin
        got_reply = pending_replies.pop_front();
        check_field("status", 32'(got_reply.status), 32'(out_status));
        check_field("position", 32'(got_reply.position), 32'(out_position));
        check_field("key", got_reply.key, out_key);
        check_field("class", 32'(got_reply.cls), 32'(out_class));
        check_field("detail", 32'(got_reply.detail), 32'(out_detail));
        check_field("entry count", 32'(got_reply.count), 32'(out_entry_count));
      end
    end
  end

  initial begin
    #3000000;
    $display("[sorted_key_table_unit] ERROR");
    $finish;
  end

  initial begin
    request_t r;
    int pick;
    int n_counted;
    int n_directed;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = '0;
    in_part_key = '0;
    in_part_class = 1'b0;
    in_detail_value = '0;
    in_slot_index = '0;
    tbl_fill = 0;
    n_errors = 0;
    n_requests = 0;
    n_replies = 0;
    n_counted = 0;

    directed_rows.push_back('{mk_req(KIND_FIND, 32'h0, 1'b0, 16'h0, 4'd0), 1'b1,
                              mk_reply(STAT_NOT_FOUND, 5'd0, 32'h0, 1'b0, 16'h0, 5'd0)});
    directed_rows.push_back('{mk_req(KIND_READ, 32'h0, 1'b0, 16'h0, 4'd15), 1'b1,
                              mk_reply(STAT_RANGE, 5'd15, 32'h0, 1'b0, 16'h0, 5'd0)});
    directed_rows.push_back('{mk_req(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 4'd15), 1'b1,
                              mk_reply(STAT_RANGE, 5'd0, 32'h0, 1'b0, 16'h0, 5'd0)});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h8000_0000, 1'b1, 16'hFFFF, 4'd0), 1'b1,
                              mk_reply(STAT_INSERTED, 5'd0, 32'h0, 1'b0, 16'h0, 5'd1)});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h0, 1'b0, 16'h0, 4'd0), 1'b1,
                              mk_reply(STAT_INSERTED, 5'd0, 32'h0, 1'b0, 16'h0, 5'd2)});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'hFFFF_FFFF, 1'b1, 16'h0, 4'd0), 1'b1,
                              mk_reply(STAT_INSERTED, 5'd2, 32'h0, 1'b0, 16'h0, 5'd3)});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h8000_0000, 1'b0, 16'h1234, 4'd0), 1'b1,
                              mk_reply(STAT_DUPLICATE, 5'd1, 32'h0, 1'b0, 16'h0, 5'd3)});
    directed_rows.push_back('{mk_req(KIND_FIND, 32'hFFFF_FFFF, 1'b0, 16'h0, 4'd0), 1'b1,
                              mk_reply(STAT_FOUND, 5'd2, 32'hFFFF_FFFF, 1'b1, 16'h0, 5'd3)});
    directed_rows.push_back('{mk_req(KIND_READ, 32'h0, 1'b0, 16'h0, 4'd1), 1'b1,
                              mk_reply(STAT_FOUND, 5'd1, 32'h8000_0000, 1'b1, 16'hFFFF, 5'd3)});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h4000_0000, 1'b0, 16'h07D0, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'hC000_0000, 1'b1, 16'h0001, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h0000_0001, 1'b0, 16'h8000, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'hFFFF_FFFE, 1'b1, 16'h7FFF, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h2000_0000, 1'b0, 16'h5555, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'hA5A5_A5A5, 1'b1, 16'hAAAA, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h5A5A_5A5A, 1'b0, 16'h1999, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h7FFF_FFFF, 1'b1, 16'h0F0F, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h8000_0001, 1'b0, 16'hF0F0, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h0000_FFFF, 1'b1, 16'h2024, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'hFFFF_0000, 1'b0, 16'h1968, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h1234_5678, 1'b1, 16'h0320, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'hDEAD_BEEF, 1'b0, 16'hBEEF, 4'd0), 1'b0, '0});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'h0000_0005, 1'b1, 16'h0005, 4'd0), 1'b1,
                              mk_reply(STAT_FULL, 5'd16, 32'h0, 1'b0, 16'h0, 5'd16)});
    directed_rows.push_back('{mk_req(KIND_INSERT, 32'hFFFF_FFFF, 1'b0, 16'h0042, 4'd0), 1'b1,
                              mk_reply(STAT_DUPLICATE, 5'd15, 32'h0, 1'b0, 16'h0, 5'd16)});
    directed_rows.push_back('{mk_req(KIND_READ, 32'h0, 1'b0, 16'h0, 4'd15), 1'b1,
                              mk_reply(STAT_FOUND, 5'd15, 32'hFFFF_FFFF, 1'b1, 16'h0, 5'd16)});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want, 1'b1);
    end
    n_directed = n_requests;

    while (n_counted < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      r.key = $urandom;
      r.cls = 1'($urandom_range(0, 1));
      r.detail = 16'($urandom_range(0, 65535));
      r.slot = 4'($urandom_range(0, 15));
      if (pick < 30) begin
        r.kind = KIND_INSERT;
        if (tbl_fill != 0 && $urandom_range(0, 1) == 1)
          r.key = tbl_key[$urandom_range(0, tbl_fill - 1)];
      end else if (pick < 65) begin
        r.kind = KIND_FIND;
        if (tbl_fill != 0 && $urandom_range(0, 9) < 7)
          r.key = tbl_key[$urandom_range(0, tbl_fill - 1)];
      end else if (pick < 95) begin
        r.kind = KIND_READ;
      end else begin
        r.kind = KIND_UNUSED;
      end
      issue_request(r, 1'b0, '0, n_counted < RANDOM_REQUESTS - CALM_TAIL);
      if (r.kind != KIND_UNUSED) n_counted++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests (%0d directed) and checked %0d results.",
             n_requests, n_directed, n_replies);
    $display("Outcomes: %0d inserted, %0d duplicate, %0d found, %0d not found, %0d full, %0d range.",
             status_hits[STAT_INSERTED], status_hits[STAT_DUPLICATE], status_hits[STAT_FOUND],
             status_hits[STAT_NOT_FOUND], status_hits[STAT_FULL], status_hits[STAT_RANGE]);
    if (n_errors == 0 && pending_replies.size() == 0) begin
      $display("[sorted_key_table_unit] OK");
    end else begin
      $display("[sorted_key_table_unit] ERROR");
    end
    $finish;
  end

endmodule
